// ----- sv/sst_pkg.sv -----
// sparse set table package: command and status codes
// no dependencies
package sst_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_ABSENT  = 3'd1,
    STAT_PRESENT = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_RANGE   = 3'd4
  } status_t;

endpackage

// ----- sv/sparse_set_table_core.sv -----
// sparse set table top level: command sequencer around sparse and dense memories
// depends on sst_pkg and sst_ram
//
// usage: drive cmd, entity_id and slot with start high while busy is low; that
// cycle is the transfer. busy stays high until the command is finished. each
// command gives exactly one result on status, found, dense_pos, entity_read and
// live_count, shown for one cycle with done high; the receiver cannot stall it.
// an out-of-range read is answered from idle; other commands step through the
// sequencer states, and lookup or erase end early on a miss. a new command may
// be given in the cycle done is high. the order of steps is set by the single
// port of each memory: erase reads the sparse slot, the dense entry, the last
// dense entry, then writes the moved sparse slot and moves the last entry into
// the freed dense position, then clears its own sparse slot.
// after reset busy stays high while all 2^INDEX_BITS sparse entries are
// cleared, one entry a cycle; no command is taken then.
module sparse_set_table_core #(
  parameter int INDEX_BITS  = 10,
  parameter int ENTITY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] entity_id,
  input  logic [9:0]  slot,
  output logic        done,
  output logic [2:0]  status,
  output logic        found,
  output logic [9:0]  dense_pos,
  output logic [31:0] entity_read,
  output logic [10:0] live_count
);
  import sst_pkg::*;

  localparam int EntW  = (ENTITY_BITS < 32) ? ENTITY_BITS : 32;
  localparam int XW    = (EntW > INDEX_BITS) ? EntW : INDEX_BITS;
  localparam int W     = (INDEX_BITS + 1 > 11) ? INDEX_BITS + 1 : 11;
  localparam int Depth = 1 << INDEX_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SPARSE, S_DENSE, S_LAST, S_UNLINK, S_READ
  } state_t;

  state_t                state;
  logic [INDEX_BITS-1:0] clr_addr;
  cmd_t                  cmd_q;
  logic [EntW-1:0]       ent_q;
  logic [INDEX_BITS-1:0] pos_q;
  logic [INDEX_BITS:0]   count;

  logic                  sp_we;
  logic [INDEX_BITS-1:0] sp_addr;
  logic [INDEX_BITS:0]   sp_wdata, sp_rdata;
  logic                  dn_we;
  logic [INDEX_BITS-1:0] dn_addr;
  logic [EntW-1:0]       dn_wdata, dn_rdata;

  logic [XW-1:0]         ent_in_x, ent_q_x, last_x;
  logic [W-1:0]          slot_x, count_x, sp_pos_x, pos_q_x;
  logic [INDEX_BITS:0]   count_dec;
  logic                  sp_live, rd_ok, dn_match;

  assign ent_in_x  = XW'(entity_id[EntW-1:0]);
  assign ent_q_x   = XW'(ent_q);
  assign last_x    = XW'(dn_rdata);
  assign slot_x    = W'(slot);
  assign count_x   = W'(count);
  assign sp_pos_x  = W'(sp_rdata[INDEX_BITS-1:0]);
  assign pos_q_x   = W'(pos_q);
  assign count_dec = count - 1'b1;
  assign sp_live   = sp_rdata[INDEX_BITS] && (sp_pos_x < count_x);
  assign rd_ok     = slot_x < count_x;
  assign dn_match  = dn_rdata == ent_q;

  assign busy       = state != S_IDLE;
  assign live_count = count_x[10:0];

  always_comb begin
    sp_we    = 1'b0;
    sp_addr  = ent_in_x[INDEX_BITS-1:0];
    sp_wdata = '0;
    dn_we    = 1'b0;
    dn_addr  = slot_x[INDEX_BITS-1:0];
    dn_wdata = ent_q;
    case (state)
      S_CLEAR: begin
        sp_we   = 1'b1;
        sp_addr = clr_addr;
      end
      S_SPARSE: begin
        sp_addr = ent_q_x[INDEX_BITS-1:0];
        if (cmd_q == CMD_INSERT) begin
          sp_wdata = {1'b1, count[INDEX_BITS-1:0]};
          dn_addr  = count[INDEX_BITS-1:0];
          if (!sp_live && !count[INDEX_BITS]) begin
            sp_we = 1'b1;
            dn_we = 1'b1;
          end
        end else begin
          dn_addr = sp_rdata[INDEX_BITS-1:0];
        end
      end
      S_DENSE: begin
        dn_addr = count_dec[INDEX_BITS-1:0];
      end
      S_LAST: begin
        sp_we    = 1'b1;
        sp_addr  = last_x[INDEX_BITS-1:0];
        sp_wdata = {1'b1, pos_q};
        dn_we    = 1'b1;
        dn_addr  = pos_q;
        dn_wdata = dn_rdata;
      end
      S_UNLINK: begin
        sp_we    = 1'b1;
        sp_addr  = ent_q_x[INDEX_BITS-1:0];
        sp_wdata = {1'b0, pos_q};
      end
      default: begin
      end
    endcase
  end

  sst_ram #(.WIDTH(INDEX_BITS + 1), .DEPTH(Depth)) u_sparse (
    .clk   (clk),
    .we    (sp_we),
    .addr  (sp_addr),
    .wdata (sp_wdata),
    .rdata (sp_rdata)
  );

  sst_ram #(.WIDTH(EntW), .DEPTH(Depth)) u_dense (
    .clk   (clk),
    .we    (dn_we),
    .addr  (dn_addr),
    .wdata (dn_wdata),
    .rdata (dn_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd_t'(cmd);
            ent_q <= entity_id[EntW-1:0];
            if (cmd_t'(cmd) == CMD_READ) begin
              if (rd_ok) begin
                state <= S_READ;
              end else begin
                done        <= 1'b1;
                status      <= STAT_RANGE;
                found       <= 1'b0;
                dense_pos   <= '0;
                entity_read <= '0;
              end
            end else begin
              state <= S_SPARSE;
            end
          end
        end
        S_READ: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          status      <= STAT_OK;
          found       <= 1'b0;
          dense_pos   <= '0;
          entity_read <= 32'(dn_rdata);
        end
        S_SPARSE: begin
          found       <= 1'b0;
          dense_pos   <= '0;
          entity_read <= '0;
          pos_q       <= sp_rdata[INDEX_BITS-1:0];
          if (cmd_q == CMD_INSERT) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (sp_live) begin
              status <= STAT_PRESENT;
            end else if (count[INDEX_BITS]) begin
              status <= STAT_FULL;
            end else begin
              status    <= STAT_OK;
              dense_pos <= count_x[9:0];
              count     <= count + 1'b1;
            end
          end else if (!sp_live) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= STAT_ABSENT;
          end else begin
            state <= S_DENSE;
          end
        end
        S_DENSE: begin
          if (!dn_match) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= STAT_ABSENT;
          end else if (cmd_q == CMD_LOOKUP) begin
            state     <= S_IDLE;
            done      <= 1'b1;
            status    <= STAT_OK;
            found     <= 1'b1;
            dense_pos <= pos_q_x[9:0];
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_UNLINK;
        end
        S_UNLINK: begin
          state  <= S_IDLE;
          done   <= 1'b1;
          status <= STAT_OK;
          count  <= count_dec;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= W'(Depth))
    else $error("live count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd_t'(cmd) != CMD_READ || rd_ok) |=> busy)
    else $error("accepted command did not raise busy");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    done && found |-> status == STAT_OK && cmd_q == CMD_LOOKUP)
    else $error("found flagged on a failed or non-lookup command");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_FULL |-> count[INDEX_BITS])
    else $error("table full reported below capacity");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !sp_we && !dn_we)
    else $error("memory write while idle");

endmodule

// ----- sv/sst_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
